@@ rtl/core/gift_pkg.sv @@
// ----------------------------------------------------------------------------
// gift_pkg
// Shared types, constants and round functions of the GIFT-128 encrypt core.
// ----------------------------------------------------------------------------
package gift_pkg;

    // Number of cipher rounds, one pipeline stage each.
    localparam int ROUND_COUNT = 40;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 1'b1;

    typedef logic [127:0] t_block;
    typedef logic [127:0] t_key;
    typedef logic [5:0]   t_rc;

    localparam logic [3:0] SBOX [0:15] = '{
        4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
        4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
    };

    // Round constants of the 6-bit LFSR, already stepped for each round.
    localparam t_rc RC_TABLE [0:39] = '{
        6'h01, 6'h03, 6'h07, 6'h0f, 6'h1f, 6'h3e, 6'h3d, 6'h3b,
        6'h37, 6'h2f, 6'h1e, 6'h3c, 6'h39, 6'h33, 6'h27, 6'h0e,
        6'h1d, 6'h3a, 6'h35, 6'h2b, 6'h16, 6'h2c, 6'h18, 6'h30,
        6'h21, 6'h02, 6'h05, 6'h0b, 6'h17, 6'h2e, 6'h1c, 6'h38,
        6'h31, 6'h23, 6'h06, 6'h0d, 6'h1b, 6'h36, 6'h2d, 6'h1a
    };

    // S-box on all 32 nibbles.
    function automatic t_block sub_cells(input t_block s);
        t_block r;
        r = '0;
        for (int n = 0; n < 32; n++) begin
            r[4*n +: 4] = SBOX[s[4*n +: 4]];
        end
        return r;
    endfunction

    // Bit permutation: bit i moves to 4*(i/16) + 32*((3*((i%16)/4) + i%4)%4) + i%4.
    function automatic t_block perm_bits(input t_block s);
        t_block r;
        int     p;
        r = '0;
        for (int i = 0; i < 128; i++) begin
            p = ((i >> 4) << 2) + (((3 * ((i >> 2) & 3) + (i & 3)) & 3) << 5) + (i & 3);
            r[p[6:0]] = s[i];
        end
        return r;
    endfunction

    function automatic logic [15:0] ror16(input logic [15:0] x, input int n);
        logic [31:0] d;
        d = {x, x} >> n;
        return d[15:0];
    endfunction

    // Key schedule step: k7..k0 becomes (k1 ror 2)||(k0 ror 12)||k7..k2.
    function automatic t_key key_update(input t_key k);
        return {ror16(k[31:16], 2), ror16(k[15:0], 12), k[127:32]};
    endfunction

endpackage

@@ rtl/core/gift_stage.sv @@
// ----------------------------------------------------------------------------
// gift_stage
// One GIFT-128 round followed by a pipeline register with valid tracking.
// ----------------------------------------------------------------------------
module gift_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  gift_pkg::t_block      i_state,
    input  logic [31:0]           i_rk_u,
    input  logic [31:0]           i_rk_v,
    input  gift_pkg::t_rc         i_rc,
    output logic                  o_valid,
    input  logic                  i_ready,
    output gift_pkg::t_block      o_state
);

    logic             r_valid;
    gift_pkg::t_block r_state;
    gift_pkg::t_block n_state;

    // The stage takes new data when it is empty or its content moves on.
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_state = gift_pkg::perm_bits(gift_pkg::sub_cells(i_state));
        for (int i = 0; i < 32; i++) begin
            n_state[4*i+2] = n_state[4*i+2] ^ i_rk_u[i];
            n_state[4*i+1] = n_state[4*i+1] ^ i_rk_v[i];
        end
        for (int i = 0; i < 6; i++) begin
            n_state[4*i+3] = n_state[4*i+3] ^ i_rc[i];
        end
        n_state[127] = ~n_state[127];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

@@ rtl/core/gift128_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// gift128_block_encrypt
// GIFT-128 block encryption, fully unrolled into one pipeline stage per round.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+------------------------------------------
//  input    | i_valid / o_ready   | i_plain_upper, i_plain_lower
//  output   | o_valid / i_ready   | o_cipher_upper, o_cipher_lower
//  config   | i_cfg_we            | i_cfg_idx, i_cfg_data (key_upper, key_lower)
//
// There is one register stage per round. A new block can enter every cycle
// unless a stall at the output has backed the pipeline up to the input.
// Each stage holds a valid bit, so an empty stage takes data even while the
// stages behind it are stalled; a stall at the output backs up only as far as
// the first empty stage. Reset (synchronous, active low) empties the pipeline
// and clears both key registers to zero.
//
// The key registers feed all stages. The per-round keys come from them by
// pure rewiring (the key schedule is word moves and rotations only), so the
// key must only change while no block is in flight.

module gift128_block_encrypt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [63:0]                    i_plain_upper,
    input  logic [63:0]                    i_plain_lower,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [63:0]                    o_cipher_upper,
    output logic [63:0]                    o_cipher_lower,
    input  logic                           i_cfg_we,
    input  logic [gift_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                    i_cfg_data
);

    localparam int NR = gift_pkg::ROUND_COUNT;

    logic [63:0] r_key_upper;
    logic [63:0] r_key_lower;

    // Stage k reads w_state[k] / w_valid[k] and drives index k+1.
    gift_pkg::t_block w_state [0:NR];
    logic             w_valid [0:NR];
    logic             w_ready [0:NR];
    gift_pkg::t_key   w_key   [0:NR-1];
    logic [NR-1:0]    w_vld_vec;

    // Key registers; writes are taken at any time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gift_pkg::REG_KEY_UPPER: r_key_upper <= i_cfg_data;
                gift_pkg::REG_KEY_LOWER: r_key_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Round key state for every round, derived by wiring from the key.
    assign w_key[0] = {r_key_upper, r_key_lower};
    for (genvar k = 1; k < NR; k++) begin : g_key
        assign w_key[k] = gift_pkg::key_update(w_key[k-1]);
    end

    assign w_state[0] = {i_plain_upper, i_plain_lower};
    assign w_valid[0] = i_valid;
    assign o_ready    = w_ready[0];
    assign w_ready[NR] = i_ready;

    for (genvar k = 0; k < NR; k++) begin : g_round
        // Round key: U = k5||k4 goes to bits 4i+2, V = k1||k0 to bits 4i+1.
        gift_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_state (w_state[k]),
            .i_rk_u  (w_key[k][95:64]),
            .i_rk_v  (w_key[k][31:0]),
            .i_rc    (gift_pkg::RC_TABLE[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_state (w_state[k+1])
        );
        assign w_vld_vec[k] = w_valid[k+1];
    end

    assign o_valid        = w_valid[NR];
    assign o_cipher_upper = w_state[NR][127:64];
    assign o_cipher_lower = w_state[NR][63:0];

    // An empty output stage means every stage can move, so input is open.
    a_ready_when_out_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage is empty");

    // The output side taking data keeps the whole pipeline moving.
    a_ready_follows_sink : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while output is being taken");

    // Blocks in flight change only by input and output transfers.
    a_occupancy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(w_vld_vec) == $countones($past(w_vld_vec))
                + 32'($past(i_valid && o_ready)) - 32'($past(o_valid && i_ready))))
        else $error("block lost or duplicated in pipeline");

    // The key changes only through a configuration write.
    a_key_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_cfg_we) |->
            $stable(r_key_upper) && $stable(r_key_lower))
        else $error("key changed without a write");

endmodule

@@ test/tb_gift128_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// tb_gift128_block_encrypt
// Self-checking testbench for the unrolled GIFT-128 block encryption pipeline.
// Blocks enter through a valid/ready channel. Each ciphertext is compared
// against a cycle-free software implementation of the cipher, which is run
// under the same key. Both channels stall at random, and one phase runs
// back to back with no gaps.
// ----------------------------------------------------------------------------
module tb_gift128_block_encrypt;

    timeunit 1ns;
    timeprecision 1ps;

    import gift_pkg::*;

    // If this many cycles pass with no transfer on either channel, the run is
    // declared hung. The worst legal silence is a key load plus one full trip
    // through the 40 stages under receiver stalls, which is far below this.
    localparam int WATCHDOG_LIMIT = 2000;

    // GIFT 4-bit S-box, kept locally so the prediction does not lean on RTL data.
    localparam logic [3:0] NIBBLE_SUB [16] = '{
        4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
        4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [63:0]          i_plain_upper;
    logic [63:0]          i_plain_lower;
    logic                 o_valid;
    logic                 i_ready;
    logic [63:0]          o_cipher_upper;
    logic [63:0]          o_cipher_lower;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [63:0]          i_cfg_data;

    gift128_block_encrypt u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_plain_upper  (i_plain_upper),
        .i_plain_lower  (i_plain_lower),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cipher_upper (o_cipher_upper),
        .o_cipher_lower (o_cipher_lower),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // Ciphertexts the pipeline still owes us, oldest first.
    t_block pending_cipher [$];

    // Local copy of the two key registers, updated with every write.
    t_key   key_shadow;

    // When set, neither the sender nor the receiver inserts idle cycles.
    bit     no_gaps;

    int     error_count;
    int     blocks_sent;
    int     blocks_checked;
    int     key_loads;
    int     idle_cycles;

    // ------------------------------------------------------------------------
    // Clock: 10 ns period.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Cipher prediction. One call runs all rounds of GIFT-128 on a block:
    // S-box layer, bit permutation, round-key and round-constant addition,
    // then the key schedule step for the next round.
    // ------------------------------------------------------------------------
    function automatic t_block gift128_encrypt(input t_block plain, input t_key key);
        t_block      st;
        t_block      shuffled;
        t_key        rk;
        logic [5:0]  rc;
        logic [15:0] w1;
        logic [15:0] w0;
        int          dst;
        st = plain;
        rk = key;
        rc = '0;
        for (int r = 0; r < ROUND_COUNT; r++) begin
            for (int n = 0; n < 32; n++) begin
                st[4*n +: 4] = NIBBLE_SUB[st[4*n +: 4]];
            end
            shuffled = '0;
            for (int b = 0; b < 128; b++) begin
                dst = 4 * (b / 16) + 32 * ((3 * ((b % 16) / 4) + (b % 4)) % 4) + (b % 4);
                shuffled[dst] = st[b];
            end
            st = shuffled;
            // Round key: U = k5||k4 goes into bit 2 of each nibble, V = k1||k0
            // into bit 1.
            for (int b = 0; b < 32; b++) begin
                st[4*b + 2] ^= rk[64 + b];
                st[4*b + 1] ^= rk[b];
            end
            // Six-bit LFSR, stepped before use; its bits land on bit 3 of the
            // low six nibbles, and the top state bit always flips.
            rc = {rc[4:0], ~(rc[5] ^ rc[4])};
            for (int b = 0; b < 6; b++) begin
                st[4*b + 3] ^= rc[b];
            end
            st[127] ^= 1'b1;
            // Key schedule: k1 rotated right by 2, k0 rotated right by 12, and
            // the remaining words move down by two positions.
            w1 = rk[31:16];
            w0 = rk[15:0];
            rk = {w1[1:0], w1[15:2], w0[11:0], w0[15:12], rk[127:32]};
        end
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. A block is offered at a falling edge and held until the
    // rising edge where o_ready is seen high. Valid is lowered only inside a gap
    // or by a drain, so a block that follows straight on never sees valid drop
    // and rise in the same time step.
    // ------------------------------------------------------------------------
    task automatic send_block(input logic [63:0] upper, input logic [63:0] lower);
        if (!no_gaps) begin
            while ($urandom_range(99) < 30) begin
                @(negedge i_clk);
                i_valid       <= 1'b0;
                i_plain_upper <= {$urandom, $urandom};
                i_plain_lower <= {$urandom, $urandom};
            end
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_plain_upper <= upper;
        i_plain_lower <= lower;
        do @(posedge i_clk); while (!o_ready);
        // The transfer happened at this edge, so the prediction uses the key
        // that is in force for this block.
        pending_cipher.push_back(gift128_encrypt({upper, lower}, key_shadow));
        blocks_sent++;
    endtask

    // Drops valid and waits until every ciphertext in flight has been
    // collected. Each block yields exactly one result, so an empty queue means
    // the pipeline is empty too.
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_cipher.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // One register write, with the write enable driven at falling edges so that it is taken at a rising edge.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_KEY_UPPER: key_shadow[127:64] = data;
            REG_KEY_LOWER: key_shadow[63:0]   = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // The key may change only while nothing is in flight.
    task automatic load_key(input t_key key);
        drain_pipeline();
        cfg_write(REG_KEY_UPPER, key[127:64]);
        cfg_write(REG_KEY_LOWER, key[63:0]);
        key_loads++;
    endtask

    // Mostly dense random blocks, with a share of sparse and structured ones
    // so that long runs of equal nibbles and single set bits also occur.
    function automatic t_block random_block();
        t_block blk;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            blk = {$urandom, $urandom, $urandom, $urandom};
        end else if (pick < 80) begin
            blk = '0;
            blk[$urandom_range(127)] = 1'b1;
        end else if (pick < 90) begin
            blk = {{64{$urandom_range(1) == 1}}, {64{$urandom_range(1) == 1}}};
        end else begin
            blk = {32{4'($urandom_range(15))}};
        end
        return blk;
    endfunction

    function automatic t_key random_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Output side. The receiver stalls at random with a chance of about 30 in
    // 100, except in the back-to-back phase.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_ready <= no_gaps || ($urandom_range(99) >= 30);
    end

    // Every ciphertext transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_block want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_cipher.size() == 0) begin
                $error("unexpected ciphertext %h_%h", o_cipher_upper, o_cipher_lower);
                error_count++;
            end else begin
                want = pending_cipher.pop_front();
                if (o_cipher_upper !== want[127:64]) begin
                    $error("cipher_upper: expected %h, got %h", want[127:64], o_cipher_upper);
                    error_count++;
                end
                if (o_cipher_lower !== want[63:0]) begin
                    $error("cipher_lower: expected %h, got %h", want[63:0], o_cipher_lower);
                    error_count++;
                end
                blocks_checked++;
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d ciphertexts outstanding", pending_cipher.size());
            $display("tb_gift128_block_encrypt: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Under the all-zero key from reset: the extreme blocks, single edge bits,
    // alternating patterns, and one block per S-box input value with that
    // nibble repeated across the whole state.
    task automatic test_reset_key_vectors();
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h8000_0000_0000_0000, '0);
        send_block('0, 64'h0000_0000_0000_0001);
        send_block({16{4'ha}}, {16{4'h5}});
        for (int v = 0; v < 16; v++) begin
            send_block({16{4'(v)}}, {16{4'(v)}});
        end
    endtask

    // The key registers at their extremes and with only one half set.
    task automatic test_extreme_keys();
        load_key('1);
        send_block('0, '0);
        send_block('1, '1);
        load_key({64'h0, 64'hffff_ffff_ffff_ffff});
        send_block({$urandom, $urandom}, {$urandom, $urandom});
        load_key({64'hffff_ffff_ffff_ffff, 64'h0});
        send_block({$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // Random blocks under a given key, with random gaps on both sides.
    task automatic test_random_blocks(input t_key key, input int count);
        t_block blk;
        load_key(key);
        for (int n = 0; n < count; n++) begin
            blk = random_block();
            send_block(blk[127:64], blk[63:0]);
        end
    endtask

    // A full-rate stretch: a new block every cycle and the receiver always
    // ready, so every stage is occupied at once.
    task automatic test_back_to_back(input int count);
        t_block blk;
        load_key(random_key());
        no_gaps = 1'b1;
        for (int n = 0; n < count; n++) begin
            blk = random_block();
            send_block(blk[127:64], blk[63:0]);
        end
        drain_pipeline();
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_plain_upper  = '0;
        i_plain_lower  = '0;
        i_ready        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_KEY_UPPER;
        i_cfg_data     = '0;
        key_shadow     = '0;
        no_gaps        = 1'b0;
        error_count    = 0;
        blocks_sent    = 0;
        blocks_checked = 0;
        key_loads      = 0;

        // Reset is asserted at the start and released at a falling edge.
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_key_vectors();
        test_extreme_keys();
        test_random_blocks(random_key(), 120);
        test_random_blocks('1, 120);
        test_random_blocks({64'h0, {$urandom, $urandom}}, 120);
        test_random_blocks({{$urandom, $urandom}, 64'h0}, 120);
        test_random_blocks(random_key(), 120);
        test_back_to_back(150);

        // Collect the tail, then keep the clock running so that any stray result
        // still shows.
        drain_pipeline();
        repeat (ROUND_COUNT + 8) @(negedge i_clk);
        if (pending_cipher.size() != 0) begin
            $error("%0d ciphertexts never arrived", pending_cipher.size());
            error_count++;
        end

        $display("Encrypted %0d blocks under %0d key loads plus the reset key; %0d checked.",
                 blocks_sent, key_loads, blocks_checked);
        $display("Covered S-box nibble sweeps, extreme keys and blocks, and a full-rate burst.");
        if (error_count == 0) begin
            $display("tb_gift128_block_encrypt: done, clean");
        end else begin
            $display("tb_gift128_block_encrypt: done, errors");
        end
        $finish;
    end

endmodule
